// ----- sv/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
// Used by spq_cell, stable_priority_queue and the testbench; no dependencies.
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int ID_W            = 16;
    localparam int PRIO_W          = 3;
    localparam int LEVEL_W         = 7;
    localparam int OCC_W           = 7;
    localparam int STATUS_W        = 3;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd62;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED    = 3'd0,
        ST_ALMOST_FULL = 3'd1,
        ST_FULL        = 3'd2,
        ST_REMOVED     = 3'd3,
        ST_EMPTY       = 3'd4
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    // Broadcast to every cell in the chain each cycle.
    typedef struct packed {
        t_cmd   cmd;
        t_entry ins;
    } t_cell_ctrl;

endpackage

// ----- sv/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, compares it against the
// incoming priority and shifts with its neighbors. Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occ,
    input  t_entry     i_left_entry,
    input  logic       i_left_ge,
    input  t_entry     i_right_entry,
    output t_entry     o_entry,
    output logic       o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    // Held entry stays in front of the new one when its priority is equal or higher.
    assign o_ge    = i_occ && (r_entry.prio >= i_ctrl.ins.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.cmd)
            CMD_INSERT: begin
                if (o_ge) begin
                    n_entry = r_entry;
                end else if (i_left_ge) begin
                    n_entry = i_ctrl.ins;
                end else begin
                    n_entry = i_left_entry;
                end
            end
            CMD_REMOVE: n_entry = i_right_entry;
            default:    n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- sv/stable_priority_queue.sv -----
// Top level of the stable priority queue: chain of spq_cell slots, entry
// count, almost-full level register and output register. Depends on spq_pkg.
//
//  channel   | valid   | ready   | payload
//  ----------+---------+---------+-------------------------------------------
//  request   | i_valid | o_ready | i_func, i_entry_id, i_priority_req
//  response  | o_valid | i_ready | o_status, o_head_id, o_head_priority,
//            |         |         | o_occupancy
//  config    | i_cfg_we| -       | i_cfg_wdata (almost-full level)
//
// One word per cycle unless the response stalls: every slot compares and shifts
// in the same cycle, and the registered response shows in the cycle after accept.
// Reset (synchronous, active low) empties the queue, sets the level to 62
// and holds o_ready low.
// A stalled response holds the output register; a new request is taken only
// when that register is free or being drained in the same cycle.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEVEL_W-1:0]  i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [ID_W-1:0]     i_entry_id,
    input  logic [PRIO_W-1:0]   i_priority_req,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_head_id,
    output logic [PRIO_W-1:0]   o_head_priority,
    output logic [OCC_W-1:0]    o_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [LEVEL_W-1:0] r_level;
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    t_entry             r_head;
    t_entry             n_head;
    logic [OCC_W-1:0]   r_occ;
    logic [EXT_W-1:0]   count_ext;
    logic [EXT_W-1:0]   count_inc_ext;

    logic       in_fire;
    logic       full;
    logic       empty;
    t_cell_ctrl ctrl;

    t_entry     cell_entry [QUEUE_DEPTH];
    logic       cell_ge    [QUEUE_DEPTH];

    assign o_ready = i_rst_n && (!r_out_valid || i_ready);
    assign in_fire = i_valid && o_ready;
    assign full    = (r_count == CNT_MAX);
    assign empty   = (r_count == '0);

    assign count_inc_ext = EXT_W'(r_count + 1'b1);

    always_comb begin
        ctrl.cmd      = CMD_HOLD;
        ctrl.ins.prio = i_priority_req;
        ctrl.ins.id   = i_entry_id;
        n_count       = r_count;
        n_status      = ST_EMPTY;
        n_head        = '0;
        if (i_func == FUNC_INSERT) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                ctrl.cmd = in_fire ? CMD_INSERT : CMD_HOLD;
                n_count  = r_count + 1'b1;
                n_status = (count_inc_ext >= EXT_W'(r_level)) ? ST_ALMOST_FULL
                                                              : ST_INSERTED;
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                ctrl.cmd = in_fire ? CMD_REMOVE : CMD_HOLD;
                n_count  = r_count - 1'b1;
                n_status = ST_REMOVED;
                n_head   = cell_entry[0];
            end
        end
    end

    assign count_ext = EXT_W'(n_count);

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_entry left_entry;
        logic   left_ge;
        t_entry right_entry;

        if (gi == 0) begin : g_first
            assign left_entry = ctrl.ins;
            assign left_ge    = 1'b1;
        end else begin : g_mid
            assign left_entry = cell_entry[gi-1];
            assign left_ge    = cell_ge[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[gi];
        end else begin : g_inner
            assign right_entry = cell_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occ         (r_count > CNT_W'(gi)),
            .i_left_entry  (left_entry),
            .i_left_ge     (left_ge),
            .i_right_entry (right_entry),
            .o_entry       (cell_entry[gi]),
            .o_ge          (cell_ge[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_level     <= LEVEL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_level <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload: load on accept, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status <= n_status;
            r_head   <= n_head;
            r_occ    <= count_ext[OCC_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_head_id       = r_head.id;
    assign o_head_priority = r_head.prio;
    assign o_occupancy     = r_occ;

endmodule

// ----- tb/sv/spq_checker.sv -----
`timescale 1ns / 1ps
// Checker for the stable priority queue: watches the request, response and
// level-write ports, keeps its own sorted copy of the queue and compares every
// response word in order. Depends on spq_pkg.
module spq_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEVEL_W-1:0]  i_cfg_wdata,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  logic                i_func,
    input  logic [ID_W-1:0]     i_entry_id,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [ID_W-1:0]     i_head_id,
    input  logic [PRIO_W-1:0]   i_head_priority,
    input  logic [OCC_W-1:0]    i_occupancy,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_full_seen,
    output int                  o_empty_seen,
    output int                  o_almost_seen
);

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [OCC_W-1:0]   occ;
    } t_queue_result;

    t_entry             held_entries[$];
    t_queue_result      due_results[$];
    logic [LEVEL_W-1:0] af_level = LEVEL_RESET;

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("%0t spq_checker: MISMATCH %s: got %0h want %0h",
                 $time, what, got, want);
    endtask

    // Update the held queue for one request word and return its response.
    function automatic t_queue_result apply_word(input logic func,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [PRIO_W-1:0] prio);
        t_queue_result r;
        t_entry        e;
        int            pos;
        r = '0;
        if (func == FUNC_INSERT) begin
            if (held_entries.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // Stay behind every entry of equal or higher priority.
                pos = held_entries.size();
                while (pos > 0 && held_entries[pos-1].prio < prio)
                    pos--;
                e.prio = prio;
                e.id   = id;
                held_entries.insert(pos, e);
                r.status = (held_entries.size() >= int'(af_level)) ? ST_ALMOST_FULL
                                                                    : ST_INSERTED;
            end
        end else if (held_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            e = held_entries.pop_front();
            r.status = ST_REMOVED;
            r.id     = e.id;
            r.prio   = e.prio;
        end
        r.occ = OCC_W'(held_entries.size());
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_queue_result want;
        if (!i_rst_n) begin
            held_entries.delete();
            due_results.delete();
            af_level = LEVEL_RESET;
        end else begin
            // Compare first: a response taken at this edge belongs to an older word.
            if (i_rsp_valid && i_rsp_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("response with nothing due", i_status, 0);
                end else begin
                    want = due_results.pop_front();
                    o_checked++;
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_head_id !== want.id)
                        report_mismatch("head_id", i_head_id, want.id);
                    if (i_head_priority !== want.prio)
                        report_mismatch("head_priority", i_head_priority, want.prio);
                    if (i_occupancy !== want.occ)
                        report_mismatch("occupancy", i_occupancy, want.occ);
                end
            end
            if (i_cfg_we)
                af_level = i_cfg_wdata;
            if (i_req_valid && i_req_ready) begin
                want = apply_word(i_func, i_entry_id, i_priority_req);
                case (want.status)
                    ST_FULL:        o_full_seen++;
                    ST_EMPTY:       o_empty_seen++;
                    ST_ALMOST_FULL: o_almost_seen++;
                    default: ;
                endcase
                due_results.push_back(want);
            end
        end
        o_pending = due_results.size();
    end

endmodule

// ----- tb/sv/tb_stable_priority_queue.sv -----
`timescale 1ns / 1ps
// Top of the stable priority queue testbench: clock, reset, request and
// response flow control, level writes and the verdict. Needs spq_pkg,
// stable_priority_queue and spq_checker.
module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int QDEPTH     = DEF_QUEUE_DEPTH;
    localparam int IDLE_LIMIT = 1000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [LEVEL_W-1:0]  i_cfg_wdata;
    logic                i_valid;
    logic                o_ready;
    logic                i_func;
    logic [ID_W-1:0]     i_entry_id;
    logic [PRIO_W-1:0]   i_priority_req;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_head_id;
    logic [PRIO_W-1:0]   o_head_priority;
    logic [OCC_W-1:0]    o_occupancy;

    int fail_count, pending, checked, full_seen, empty_seen, almost_seen;
    int idle_cycles = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    stable_priority_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_entry_id     (i_entry_id),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_head_id      (o_head_id),
        .o_head_priority(o_head_priority),
        .o_occupancy    (o_occupancy)
    );

    spq_checker #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_spq_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_func         (i_func),
        .i_entry_id     (i_entry_id),
        .i_priority_req (i_priority_req),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_status       (o_status),
        .i_head_id      (o_head_id),
        .i_head_priority(o_head_priority),
        .i_occupancy    (o_occupancy),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen),
        .o_almost_seen  (almost_seen)
    );

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    task automatic send_word(input logic func, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio);
        int gap;
        gap = gaps_on ? pick_pause() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid        = 1'b0;
            i_func         = 1'($urandom);
            i_entry_id     = ID_W'($urandom);
            i_priority_req = PRIO_W'($urandom);
        end
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_func         = func;
        i_entry_id     = id;
        i_priority_req = prio;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold off until every response is back, then let the pipeline settle.
    task automatic drain_queue();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_level(input logic [LEVEL_W-1:0] level);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = level;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic run_segment(input int n_words, input int insert_pct);
        logic [PRIO_W-1:0] prio;
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        repeat (n_words) begin
            // Crowd half the inserts onto two levels so ties are common.
            prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 7))
                                        : PRIO_W'($urandom_range(4, 5));
            send_word(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE,
                      ID_W'($urandom), prio);
        end
    endtask

    // Fill past full, churn, then drain past empty at one level setting.
    task automatic run_phase(input logic [LEVEL_W-1:0] level);
        drain_queue();
        write_level(level);
        run_segment(90, 85);
        run_segment(40, 50);
        run_segment(90, 15);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_func         = FUNC_INSERT;
        i_entry_id     = '0;
        i_priority_req = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words at the reset level: empty remove, extremes, ties.
        send_word(FUNC_REMOVE, 16'hFFFF, 3'd7);
        send_word(FUNC_INSERT, 16'h0000, 3'd0);
        send_word(FUNC_INSERT, 16'hFFFF, 3'd7);
        send_word(FUNC_INSERT, 16'h1234, 3'd3);
        send_word(FUNC_INSERT, 16'h1235, 3'd3);
        send_word(FUNC_INSERT, 16'h5555, 3'd7);
        send_word(FUNC_INSERT, 16'hAAAA, 3'd0);
        repeat (6) send_word(FUNC_REMOVE, ID_W'($urandom), PRIO_W'($urandom));
        send_word(FUNC_REMOVE, 16'h0000, 3'd0);
        send_word(FUNC_INSERT, 16'h00F5, 3'd5);
        send_word(FUNC_INSERT, 16'h00F1, 3'd1);
        send_word(FUNC_INSERT, 16'h00F6, 3'd6);
        send_word(FUNC_INSERT, 16'h00F8, 3'd5);
        repeat (5) send_word(FUNC_REMOVE, ID_W'($urandom), PRIO_W'($urandom));

        run_phase(7'd0);
        run_phase(7'd127);
        run_phase(7'd64);
        run_phase(7'd65);
        run_phase(7'd1);
        run_phase(7'd63);
        run_phase(LEVEL_W'($urandom_range(0, 127)));

        drain_queue();
        repeat (5) @(posedge i_clk);
        $display("checked %0d response words over 8 almost-full levels", checked);
        $display("  %0d rejected full, %0d empty removes, %0d almost-full inserts",
                 full_seen, empty_seen, almost_seen);
        if (fail_count == 0)
            $display("tb_stable_priority_queue passed");
        else
            $display("tb_stable_priority_queue failed");
        $finish;
    end

    // Response side back-pressure.
    initial begin : rsp_flow
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else if (!stalls_on || $urandom_range(0, 99) < 70) begin
                i_ready = 1'b1;
            end else begin
                i_ready    = 1'b0;
                stall_left = pick_pause();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("tb_stable_priority_queue failed");
                $finish;
            end
        end
    end

endmodule
